/* src/pmtd_pkg.sv */
`default_nettype none
package pmtd_pkg;

    // packet layout
    localparam logic [5:0] NUM_FIELDS     = 6'd35;
    localparam logic [5:0] MODE_FIELD     = 6'd34;
    localparam logic [7:0] MIN_LEN        = 8'd8;
    localparam logic [7:0] MAX_LEN        = 8'd145;
    localparam logic [7:0] COUNT_MAX      = 8'd255;
    localparam logic [7:0] MASK_FIRST_IDX = 8'd3;
    localparam logic [7:0] MASK_LAST_IDX  = 8'd6;
    localparam logic [7:0] MASK_TAIL_IDX  = 8'd7;
    localparam logic [1:0] WORD_LAST_BYTE = 2'd3;

    // values given for absent fields
    localparam logic [31:0] FIELD_ABSENT = 32'hFFFF_FFFF;
    localparam logic [31:0] MODE_ABSENT  = 32'h0000_00FF;

    // result kinds
    localparam logic RESULT_FIELD  = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    // packet status codes
    typedef logic [1:0] t_pkt_status;
    localparam t_pkt_status STATUS_OK    = 2'd0;
    localparam t_pkt_status STATUS_SHORT = 2'd1;
    localparam t_pkt_status STATUS_LONG  = 2'd2;
    localparam t_pkt_status STATUS_TRUNC = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_field;
        logic emit_absent;
        logic emit_status;
        logic last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pending;
        logic absent_now;
        logic absent_after;
        logic eop;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* src/pmtd_if.sv */
`default_nettype none
interface pmtd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface pmtd_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [5:0]         field_number;
    logic signed [31:0] field_value;
    logic               field_present;
    logic [1:0]         packet_status;
    logic               last_result;

    modport source (output valid, output result_kind, output field_number,
                    output field_value, output field_present, output packet_status,
                    output last_result, input ready);
    modport sink   (input valid, input result_kind, input field_number,
                    input field_value, input field_present, input packet_status,
                    input last_result, output ready);
endinterface
`default_nettype wire

/* src/pmtd_ctrl.sv */
`default_nettype none
module pmtd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pmtd_pkg::t_sts i_sts,
    output pmtd_pkg::t_cmd     o_cmd
);
    import pmtd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // one result per cycle while the output is free, field before absent run before status
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (i_sts.pending) begin
                    o_cmd.emit_field = i_sts.out_free;
                    o_cmd.last       = !i_sts.absent_after && !i_sts.eop;
                end else if (i_sts.absent_now) begin
                    o_cmd.emit_absent = i_sts.out_free;
                    o_cmd.last        = !i_sts.absent_after && !i_sts.eop;
                end else if (i_sts.eop) begin
                    o_cmd.emit_status = i_sts.out_free;
                    o_cmd.last        = 1'b1;
                    if (i_sts.out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* src/pmtd_dp.sv */
`default_nettype none
module pmtd_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pmtd_pkg::t_cmd i_cmd,
    output pmtd_pkg::t_sts      o_sts,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_packet,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic                o_result_kind,
    output logic [5:0]          o_field_number,
    output logic signed [31:0]  o_field_value,
    output logic                o_field_present,
    output logic [1:0]          o_packet_status,
    output logic                o_last_result
);
    import pmtd_pkg::*;

    // packet state
    logic [7:0]  r_byte_count, n_byte_count;
    logic [34:0] r_mask,       n_mask;
    logic [5:0]  r_next_field, n_next_field;
    logic [1:0]  r_byte_in_field, n_byte_in_field;
    logic [23:0] r_word,       n_word;
    logic        r_pending,    n_pending;
    logic [7:0]  r_byte;
    logic        r_eop;

    // output register
    logic               r_out_valid;
    logic               r_out_kind;
    logic [5:0]         r_out_number;
    logic signed [31:0] r_out_value;
    logic               r_out_present;
    t_pkt_status        r_out_status;
    logic               r_out_last;

    logic        w_emit;
    logic        w_mask_known;
    logic [5:0]  w_after_field;
    t_pkt_status w_status;

    function automatic logic field_absent(input logic [34:0] mask, input logic [5:0] f);
        logic [5:0] bit_idx;
        bit_idx = MODE_FIELD - f;
        field_absent = (f < NUM_FIELDS) ? !mask[bit_idx] : 1'b0;
    endfunction

    assign w_emit        = i_cmd.emit_field || i_cmd.emit_absent || i_cmd.emit_status;
    assign w_mask_known  = (r_byte_count >= MIN_LEN);
    assign w_after_field = r_next_field + 6'd1;

    // status flags for the controller
    always_comb begin
        o_sts.pending      = r_pending;
        o_sts.absent_now   = w_mask_known && field_absent(r_mask, r_next_field);
        o_sts.absent_after = w_mask_known && field_absent(r_mask, w_after_field);
        o_sts.eop          = r_eop;
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    // packet status at the last byte
    always_comb begin
        if (r_byte_count < MIN_LEN) begin
            w_status = STATUS_SHORT;
        end else if (r_byte_count > MAX_LEN) begin
            w_status = STATUS_LONG;
        end else if (r_next_field < NUM_FIELDS) begin
            w_status = STATUS_TRUNC;
        end else begin
            w_status = STATUS_OK;
        end
    end

    // state update on byte accept and on each emitted result
    always_comb begin
        n_byte_count    = r_byte_count;
        n_mask          = r_mask;
        n_next_field    = r_next_field;
        n_byte_in_field = r_byte_in_field;
        n_word          = r_word;
        n_pending       = r_pending;
        if (i_cmd.accept) begin
            if (r_byte_count >= MASK_FIRST_IDX && r_byte_count <= MASK_LAST_IDX) begin
                n_mask = {r_mask[26:0], i_data_byte};
            end else if (r_byte_count == MASK_TAIL_IDX) begin
                n_mask = {r_mask[31:0], i_data_byte[7:5]};
            end else if (r_byte_count > MASK_TAIL_IDX && r_next_field < NUM_FIELDS) begin
                if (r_next_field == MODE_FIELD || r_byte_in_field == WORD_LAST_BYTE) begin
                    n_pending = 1'b1;
                end else begin
                    case (r_byte_in_field)
                        2'd0:    n_word[7:0]   = i_data_byte;
                        2'd1:    n_word[15:8]  = i_data_byte;
                        2'd2:    n_word[23:16] = i_data_byte;
                        default: n_word        = r_word;
                    endcase
                    n_byte_in_field = r_byte_in_field + 2'd1;
                end
            end
            if (r_byte_count != COUNT_MAX) begin
                n_byte_count = r_byte_count + 8'd1;
            end
        end
        if (i_cmd.emit_field) begin
            n_pending       = 1'b0;
            n_word          = '0;
            n_byte_in_field = '0;
        end
        if (i_cmd.emit_field || i_cmd.emit_absent) begin
            n_next_field = w_after_field;
        end
        if (i_cmd.emit_status) begin
            n_byte_count    = '0;
            n_mask          = '0;
            n_next_field    = '0;
            n_byte_in_field = '0;
            n_word          = '0;
            n_pending       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_mask          <= '0;
            r_next_field    <= '0;
            r_byte_in_field <= '0;
            r_word          <= '0;
            r_pending       <= 1'b0;
            r_eop           <= 1'b0;
        end else begin
            r_byte_count    <= n_byte_count;
            r_mask          <= n_mask;
            r_next_field    <= n_next_field;
            r_byte_in_field <= n_byte_in_field;
            r_word          <= n_word;
            r_pending       <= n_pending;
            if (i_cmd.accept) begin
                r_eop <= i_end_of_packet;
            end
        end
    end

    // byte held for the field it completes
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_last <= i_cmd.last;
            if (i_cmd.emit_status) begin
                r_out_kind    <= RESULT_STATUS;
                r_out_number  <= '0;
                r_out_value   <= '0;
                r_out_present <= 1'b0;
                r_out_status  <= w_status;
            end else begin
                r_out_kind    <= RESULT_FIELD;
                r_out_number  <= r_next_field;
                r_out_present <= i_cmd.emit_field;
                r_out_status  <= STATUS_OK;
                if (i_cmd.emit_field) begin
                    if (r_next_field == MODE_FIELD) begin
                        r_out_value <= signed'({24'd0, r_byte});
                    end else begin
                        r_out_value <= signed'({r_byte, r_word});
                    end
                end else begin
                    if (r_next_field == MODE_FIELD) begin
                        r_out_value <= signed'(MODE_ABSENT);
                    end else begin
                        r_out_value <= signed'(FIELD_ABSENT);
                    end
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_field_number  = r_out_number;
    assign o_field_value   = r_out_value;
    assign o_field_present = r_out_present;
    assign o_packet_status = r_out_status;
    assign o_last_result   = r_out_last;

endmodule
`default_nettype wire

/* src/presence_mask_telemetry_deframer_core.sv */
// Presence-mask telemetry deframer.
// Input channel i_in: one packet byte per transaction, end_of_packet set on
// the last byte. Bytes 3 to 7 carry the 35-bit presence mask; present fields
// follow as little-endian 32-bit words, the mode field as one byte.
// Output channel o_out: decoded fields in mask order as each resolves, and a
// status result after the last byte; last_result marks the final result that
// a byte produced. On an error status the consumer drops the packet's fields.
// Timing: a byte is taken in ST_IDLE and its results then leave one per
// cycle from ST_BUSY while the output register is free. After the last
// result of a byte the controller returns to ST_IDLE through an idle ST_BUSY
// step, but the status result returns it to ST_IDLE as it is issued (up to
// 36 results on an eighth byte that ends the packet). The controller issues
// results one at a time into the single output register. The first result is
// issued from ST_BUSY once the byte is registered, and lands in the output
// register. A new byte is taken only after the previous one has finished.
// Receiver stall: the output register holds its result while ready is low,
// and the controller waits while the register is held; no result is lost
// or repeated.
// Reset (synchronous, active low): packet state and the output valid clear,
// the block is ready for the first byte of a packet at once.
`default_nettype none
module presence_mask_telemetry_deframer_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pmtd_in_if.sink    i_in,
    pmtd_out_if.source o_out
);
    import pmtd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    pmtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pmtd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_data_byte     (i_in.data_byte),
        .i_end_of_packet (i_in.end_of_packet),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_result_kind   (o_out.result_kind),
        .o_field_number  (o_out.field_number),
        .o_field_value   (o_out.field_value),
        .o_field_present (o_out.field_present),
        .o_packet_status (o_out.packet_status),
        .o_last_result   (o_out.last_result)
    );

    // at most one result issued per cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.emit_field, w_cmd.emit_absent, w_cmd.emit_status}))
        else $error("more than one result issued in a cycle");

    // a result is issued only into a free output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_field || w_cmd.emit_absent || w_cmd.emit_status) |-> w_sts.out_free)
        else $error("result issued over a waiting result");

    // one byte in flight: no second transaction straight after the first
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a byte is in progress");

    // a status result always closes the byte's results
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == RESULT_STATUS) |-> o_out.last_result)
        else $error("status result not marked last");

endmodule
`default_nettype wire

/* tb/pmtd_checker.sv */
`timescale 1ns / 1ps
module pmtd_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pmtd_in_if   i_in_mon,
    pmtd_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_outstanding
);
    import pmtd_pkg::*;

    typedef struct {
        logic               result_kind;
        logic [5:0]         field_number;
        logic signed [31:0] field_value;
        logic               field_present;
        t_pkt_status        packet_status;
        logic               last_result;
    } t_result;

    // deframer state as seen from the byte stream
    logic [7:0]  pkt_len;
    logic [34:0] field_map;
    logic [5:0]  cur_field;
    logic [1:0]  word_pos;
    logic [23:0] word_acc;

    t_result decoded_q[$];
    int      mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic void clear_packet();
        pkt_len   = '0;
        field_map = '0;
        cur_field = '0;
        word_pos  = '0;
        word_acc  = '0;
    endfunction

    function automatic void push_result(logic kind, logic [5:0] num, logic [31:0] val,
                                        logic pres, t_pkt_status st);
        t_result r;
        r.result_kind   = kind;
        r.field_number  = num;
        r.field_value   = val;
        r.field_present = pres;
        r.packet_status = st;
        r.last_result   = 1'b0;
        decoded_q.push_back(r);
    endfunction

    // absent fields resolve at once up to the next present one
    function automatic void flush_absent();
        while (cur_field < NUM_FIELDS && !field_map[MODE_FIELD - cur_field]) begin
            push_result(RESULT_FIELD, cur_field,
                        (cur_field == MODE_FIELD) ? MODE_ABSENT : FIELD_ABSENT,
                        1'b0, STATUS_OK);
            cur_field++;
        end
    endfunction

    // expected results for one packet byte
    function automatic void deframe_byte(logic [7:0] b, logic eop);
        int          first_new;
        t_pkt_status st;
        first_new = decoded_q.size();
        if (pkt_len >= MASK_FIRST_IDX && pkt_len <= MASK_LAST_IDX) begin
            field_map = {field_map[26:0], b};
        end else if (pkt_len == MASK_TAIL_IDX) begin
            field_map = {field_map[31:0], b[7:5]};
            flush_absent();
        end else if (pkt_len > MASK_TAIL_IDX && cur_field < NUM_FIELDS) begin
            if (cur_field == MODE_FIELD) begin
                push_result(RESULT_FIELD, MODE_FIELD, {24'd0, b}, 1'b1, STATUS_OK);
                cur_field++;
                flush_absent();
            end else if (word_pos == WORD_LAST_BYTE) begin
                push_result(RESULT_FIELD, cur_field, {b, word_acc}, 1'b1, STATUS_OK);
                cur_field++;
                word_pos = '0;
                word_acc = '0;
                flush_absent();
            end else begin
                word_acc[8 * word_pos +: 8] = b;
                word_pos++;
            end
        end

        if (pkt_len != COUNT_MAX)
            pkt_len++;

        if (eop) begin
            if (pkt_len < MIN_LEN)
                st = STATUS_SHORT;
            else if (pkt_len > MAX_LEN)
                st = STATUS_LONG;
            else if (cur_field < NUM_FIELDS)
                st = STATUS_TRUNC;
            else
                st = STATUS_OK;
            push_result(RESULT_STATUS, '0, '0, 1'b0, st);
            clear_packet();
        end

        if (decoded_q.size() > first_new)
            decoded_q[decoded_q.size() - 1].last_result = 1'b1;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        t_result want;
        if (decoded_q.size() == 0) begin
            $error("unexpected result: kind %0d field %0d value 0x%0h status %0d",
                   i_out_mon.result_kind, i_out_mon.field_number,
                   i_out_mon.field_value, i_out_mon.packet_status);
            mismatch_count++;
        end else begin
            want = decoded_q.pop_front();
            compare_field("result_kind", want.result_kind, i_out_mon.result_kind);
            compare_field("field_number", want.field_number, i_out_mon.field_number);
            compare_field("field_value", want.field_value, i_out_mon.field_value);
            compare_field("field_present", want.field_present, i_out_mon.field_present);
            compare_field("packet_status", want.packet_status, i_out_mon.packet_status);
            compare_field("last_result", want.last_result, i_out_mon.last_result);
        end
    endfunction

    // byte transactions feed the prediction, result transactions are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_packet();
            decoded_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                deframe_byte(i_in_mon.data_byte, i_in_mon.end_of_packet);
            if (i_out_mon.valid && i_out_mon.ready)
                check_result();
            o_outstanding <= decoded_q.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import pmtd_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int SATURATE_MAX = COUNT_MAX + 7;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum {PKT_GOOD, PKT_TRUNC, PKT_SHORT, PKT_LONG, PKT_MASK_ONLY, PKT_SATURATE}
        t_pkt_kind;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int outstanding;
    int sent_items  = 0;
    int idle_cycles = 0;

    logic [7:0] pkt_bytes[$];

    pmtd_in_if  in_ch();
    pmtd_out_if out_ch();

    presence_mask_telemetry_deframer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pmtd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #1 i_clk = ~i_clk;

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver back-pressure: long open stretches and stalls of varied length
    initial begin : ready_gen
        int run;
        int stall;
        int pick;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            pick = $urandom_range(0, 9);
            if (pick < 3)
                stall = 0;
            else if (pick < 8)
                stall = $urandom_range(1, 3);
            else
                stall = $urandom_range(10, 40);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic build_packet(t_pkt_kind kind);
        logic [34:0] mask;
        logic [31:0] word;
        int          density;
        int          len;
        pkt_bytes.delete();
        case (kind)
            PKT_SHORT: begin
                len = $urandom_range(1, MIN_LEN - 1);
                repeat (len) pkt_bytes.push_back(8'($urandom));
            end
            PKT_LONG: begin
                len = $urandom_range(MAX_LEN + 1, MAX_LEN + 5);
                repeat (len) pkt_bytes.push_back(8'($urandom));
            end
            PKT_SATURATE: begin
                len = $urandom_range(COUNT_MAX + 1, COUNT_MAX + 7);
                repeat (len) pkt_bytes.push_back(8'($urandom));
            end
            default: begin
                // mostly sparse masks, some medium, now and then every field
                density = $urandom_range(0, 9);
                for (int i = 0; i < 35; i++) begin
                    if (density < 6)
                        mask[i] = ($urandom_range(0, 15) == 0);
                    else if (density < 9)
                        mask[i] = ($urandom_range(0, 3) == 0);
                    else
                        mask[i] = 1'b1;
                end
                if (density < 9)
                    mask[0] = $urandom_range(0, 1);
                repeat (3) pkt_bytes.push_back(8'($urandom));
                pkt_bytes.push_back(mask[34:27]);
                pkt_bytes.push_back(mask[26:19]);
                pkt_bytes.push_back(mask[18:11]);
                pkt_bytes.push_back(mask[10:3]);
                pkt_bytes.push_back({mask[2:0], 5'($urandom)});
                if (kind != PKT_MASK_ONLY) begin
                    for (int f = 0; f < MODE_FIELD; f++) begin
                        if (mask[MODE_FIELD - f]) begin
                            word = pick_word();
                            pkt_bytes.push_back(word[7:0]);
                            pkt_bytes.push_back(word[15:8]);
                            pkt_bytes.push_back(word[23:16]);
                            pkt_bytes.push_back(word[31:24]);
                        end
                    end
                    if (mask[0])
                        pkt_bytes.push_back(8'($urandom));
                    // surplus payload after the last field
                    if (kind == PKT_GOOD && $urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
                    if (kind == PKT_TRUNC && pkt_bytes.size() > MIN_LEN) begin
                        len = $urandom_range(MIN_LEN, pkt_bytes.size() - 1);
                        while (pkt_bytes.size() > len)
                            void'(pkt_bytes.pop_back());
                    end
                end
            end
        endcase
    endtask

    // one byte transaction, with an optional gap before it
    task automatic send_byte(logic [7:0] b, logic last, bit burst);
        int gap;
        int pick;
        gap = 0;
        if (!burst) begin
            pick = $urandom_range(0, 9);
            if (pick >= 9)
                gap = $urandom_range(5, 30);
            else if (pick >= 6)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_packet <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_packet(bit burst);
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, burst);
    endtask

    // hold the sender off until every predicted result has left
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin : stimulus
        t_pkt_kind kind;
        int        pick;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= 8'h00;
        in_ch.end_of_packet <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-byte packet, too short
        pkt_bytes = '{8'hFF};
        send_packet(1'b0);
        // empty mask with ignored bits set: every field absent on byte 7
        pkt_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F};
        send_packet(1'b1);
        // mode field only, top value, then a surplus byte
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3F, 8'hFF, 8'hA5};
        send_packet(1'b0);
        // full mask ending at the mask: truncated
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet(1'b0);
        wait_drained();

        // random packets, most of them well formed, leaving room for the last one
        while (sent_items + SATURATE_MAX < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                kind = PKT_GOOD;
            else if (pick < 75)
                kind = PKT_TRUNC;
            else if (pick < 85)
                kind = PKT_SHORT;
            else if (pick < 93)
                kind = PKT_LONG;
            else
                kind = PKT_MASK_ONLY;
            build_packet(kind);
            if (sent_items + pkt_bytes.size() + SATURATE_MAX > RANDOM_ITEMS)
                continue;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            send_packet($urandom_range(0, 3) == 0);
        end

        // one packet long enough to saturate the byte count
        build_packet(PKT_SATURATE);
        send_packet(1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/pmtd_pkg.sv
src/pmtd_if.sv
src/pmtd_ctrl.sv
src/pmtd_dp.sv
src/presence_mask_telemetry_deframer_core.sv
tb/pmtd_checker.sv
tb/tb.sv
